[src/mfs_pkg.sv]
// Package with the types, sizes and codes of the maximum frequency stack.
package mfs_pkg;

  localparam int ENTRY_CAPACITY    = 1024;
  localparam int DISTINCT_CAPACITY = 256;
  localparam int VALUE_BITS        = 30;

  localparam int ENTRY_AW = $clog2(ENTRY_CAPACITY);
  localparam int KEY_AW   = $clog2(DISTINCT_CAPACITY);
  localparam int CNT_W    = $clog2(ENTRY_CAPACITY + 1);
  localparam int VAL_W    = 30;

  localparam logic [VAL_W-1:0] VALUE_MASK = VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [VAL_W-1:0] push_value;
  } mfs_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] popped_value;
    logic [1:0]       status;
  } mfs_rsp_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
  } mfs_key_t;

  typedef struct packed {
    logic [ENTRY_AW-1:0] top;
    logic [CNT_W-1:0]    size;
  } mfs_level_t;

  typedef struct packed {
    logic [VAL_W-1:0]    value;
    logic [ENTRY_AW-1:0] below;
    logic [KEY_AW-1:0]   slot;
  } mfs_entry_t;

endpackage

[src/max_frequency_stack.sv]
// Top level of the maximum frequency stack: control sequencer and state memories.
//
//   channel  ports                      handshake
//   input    start, busy, in_req        taken when start is high and busy is low
//   result   out_valid, out_result      shown for one cycle, always taken
//
// A pop steps through level read, entry read, count read and count write back.
// A push scans the count table one slot a cycle and then writes the key and
// stacks the entry.
// An empty pop or a push with no free entry answers in the cycle after acceptance.
// After reset the block is idle and empty at once; no clearing pass is needed.
// The receiver cannot stall, so one transaction is in work at a time.
module max_frequency_stack
  import mfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mfs_req_t in_req,
  output logic     out_valid,
  output mfs_rsp_t out_result
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_PREP, S_PUSH_WR, S_POP_LVL, S_POP_ENT, S_POP_KEY
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    top_r, top_nxt;
  logic [CNT_W-1:0]    hw_r, hw_nxt;
  logic [CNT_W-1:0]    freed_r, freed_nxt;
  logic [DISTINCT_CAPACITY-1:0] valid_r, valid_nxt;
  logic [VAL_W-1:0]    v_r, v_nxt;
  logic [KEY_AW-1:0]   slot_r, slot_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [KEY_AW:0]     scan_r, scan_nxt;
  logic [KEY_AW-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic                free_found_r, free_found_nxt;
  logic [KEY_AW-1:0]   free_slot_r, free_slot_nxt;
  logic [ENTRY_AW-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]    size_r, size_nxt;
  logic                out_valid_r, out_valid_nxt;
  mfs_rsp_t            out_r, out_nxt;

  // Memories.
  mfs_key_t            key_mem [DISTINCT_CAPACITY];
  mfs_level_t          level_mem [ENTRY_CAPACITY];
  mfs_entry_t          entry_mem [ENTRY_CAPACITY];
  logic [ENTRY_AW-1:0] free_mem [ENTRY_CAPACITY];

  mfs_key_t            key_q, key_wd;
  mfs_level_t          level_q, level_wd;
  mfs_entry_t          entry_q, entry_wd;
  logic [ENTRY_AW-1:0] free_q, free_wd;
  logic [KEY_AW-1:0]   key_ra, key_wa;
  logic [ENTRY_AW-1:0] level_ra, level_wa, entry_ra, entry_wa, free_ra, free_wa;
  logic                key_we, level_we, entry_we, free_we;

  logic                accept;
  logic                hit;
  logic [CNT_W-1:0]    lvl_m1, top_m1, new_size, cnt_dec;
  logic [ENTRY_AW-1:0] alloc_idx;

  assign accept  = start && !busy;
  assign lvl_m1  = cnt_r - CNT_W'(1);
  assign top_m1  = top_r - CNT_W'(1);
  assign hit     = cmp_vld_r && valid_r[cmp_idx_r] && (key_q.value == v_r);
  assign cnt_dec = key_q.count - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    hw_nxt         = hw_r;
    freed_nxt      = freed_r;
    valid_nxt      = valid_r;
    v_nxt          = v_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    scan_nxt       = scan_r;
    cmp_idx_nxt    = scan_r[KEY_AW-1:0];
    cmp_vld_nxt    = 1'b0;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    idx_nxt        = idx_r;
    size_nxt       = size_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;
    key_ra   = scan_r[KEY_AW-1:0];
    key_wa   = slot_r;
    key_wd   = '{value: v_r, count: cnt_r};
    key_we   = 1'b0;
    level_ra = top_m1[ENTRY_AW-1:0];
    level_wa = lvl_m1[ENTRY_AW-1:0];
    level_wd = '{top: idx_r, size: size_r};
    level_we = 1'b0;
    entry_ra = level_q.top;
    entry_wa = idx_r;
    entry_wd = '{value: v_r, below: level_q.top, slot: slot_r};
    entry_we = 1'b0;
    free_ra  = freed_r[ENTRY_AW-1:0] - ENTRY_AW'(1);
    free_wa  = freed_r[ENTRY_AW-1:0];
    free_wd  = idx_r;
    free_we  = 1'b0;
    new_size  = '0;
    alloc_idx = (freed_r != '0) ? free_q : hw_r[ENTRY_AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.req_type == REQ_PUSH) begin
            v_nxt = in_req.push_value & VALUE_MASK;
            if (freed_r == '0 && hw_r == CNT_W'(ENTRY_CAPACITY)) begin
              out_valid_nxt = 1'b1;
              out_nxt       = '{popped_value: '0, status: ST_FULL};
            end else begin
              scan_nxt       = '0;
              free_found_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
          end else if (top_r == '0) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{popped_value: '0, status: ST_EMPTY};
          end else begin
            // Read the newest entry index of the top level.
            state_nxt = S_POP_LVL;
          end
        end
      end
      S_SCAN: begin
        // Read one slot a cycle; compare the slot read in the cycle before.
        scan_nxt    = scan_r + (KEY_AW+1)'(1);
        cmp_vld_nxt = (scan_r < (KEY_AW+1)'(DISTINCT_CAPACITY));
        if (cmp_vld_r && !valid_r[cmp_idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_slot_nxt  = cmp_idx_r;
        end
        if (hit) begin
          slot_nxt  = cmp_idx_r;
          cnt_nxt   = key_q.count + CNT_W'(1);
          state_nxt = S_PREP;
        end else if (cmp_vld_r && cmp_idx_r == KEY_AW'(DISTINCT_CAPACITY - 1)) begin
          if (free_found_r) begin
            slot_nxt  = free_slot_r;
            cnt_nxt   = CNT_W'(1);
            state_nxt = S_PREP;
          end else if (!valid_r[cmp_idx_r]) begin
            slot_nxt  = cmp_idx_r;
            cnt_nxt   = CNT_W'(1);
            state_nxt = S_PREP;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{popped_value: '0, status: ST_FULL};
            state_nxt     = S_IDLE;
          end
        end
      end
      S_PREP: begin
        key_we            = 1'b1;
        valid_nxt[slot_r] = 1'b1;
        level_ra          = lvl_m1[ENTRY_AW-1:0];
        state_nxt         = S_PUSH_WR;
      end
      S_PUSH_WR: begin
        // Levels above the top level are empty whatever the memory holds.
        new_size = ((cnt_r > top_r) ? '0 : level_q.size) + CNT_W'(1);
        entry_wa = alloc_idx;
        entry_we = 1'b1;
        level_wd = '{top: alloc_idx, size: new_size};
        level_we = 1'b1;
        if (freed_r != '0) begin
          freed_nxt = freed_r - CNT_W'(1);
        end else begin
          hw_nxt = hw_r + CNT_W'(1);
        end
        if (cnt_r > top_r) begin
          top_nxt = cnt_r;
        end
        out_valid_nxt = 1'b1;
        out_nxt       = '{popped_value: '0, status: ST_OK};
        state_nxt     = S_IDLE;
      end
      S_POP_LVL: begin
        idx_nxt   = level_q.top;
        size_nxt  = level_q.size;
        state_nxt = S_POP_ENT;
      end
      S_POP_ENT: begin
        v_nxt     = entry_q.value;
        slot_nxt  = entry_q.slot;
        key_ra    = entry_q.slot;
        level_wa  = top_m1[ENTRY_AW-1:0];
        level_wd  = '{top: entry_q.below, size: size_r - CNT_W'(1)};
        level_we  = 1'b1;
        free_we   = 1'b1;
        freed_nxt = freed_r + CNT_W'(1);
        if (size_r == CNT_W'(1)) begin
          top_nxt = top_m1;
        end
        state_nxt = S_POP_KEY;
      end
      S_POP_KEY: begin
        key_wd = '{value: key_q.value, count: cnt_dec};
        key_we = 1'b1;
        if (cnt_dec == '0) begin
          valid_nxt[slot_r] = 1'b0;
        end
        out_valid_nxt = 1'b1;
        out_nxt       = '{popped_value: v_r, status: ST_OK};
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      top_r        <= '0;
      hw_r         <= '0;
      freed_r      <= '0;
      valid_r      <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      top_r        <= top_nxt;
      hw_r         <= hw_nxt;
      freed_r      <= freed_nxt;
      valid_r      <= valid_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    v_r         <= v_nxt;
    slot_r      <= slot_nxt;
    cnt_r       <= cnt_nxt;
    scan_r      <= scan_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    free_slot_r <= free_slot_nxt;
    idx_r       <= idx_nxt;
    size_r      <= size_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    key_q <= key_mem[key_ra];
  end

  always_ff @(posedge clk) begin
    if (level_we) begin
      level_mem[level_wa] <= level_wd;
    end
    level_q <= level_mem[level_ra];
  end

  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[entry_wa] <= entry_wd;
    end
    entry_q <= entry_mem[entry_ra];
  end

  always_ff @(posedge clk) begin
    if (free_we) begin
      free_mem[free_wa] <= free_wd;
    end
    free_q <= free_mem[free_ra];
  end

  assign busy       = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_r;

endmodule

[src/mfs_checker.sv]
// Port-level checks of the maximum frequency stack and their bind.
module mfs_checker
  import mfs_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input mfs_req_t in_req,
  input logic     out_valid,
  input mfs_rsp_t out_result
);

  // Every accepted transaction either answers at once or holds the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted transaction neither answered nor busy");

  // A failed result never carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result.status != ST_OK || $past(in_req.req_type == REQ_PUSH
      && start && !busy)) |-> out_result.popped_value == '0)
    else $error("nonzero value on a result without a popped entry");

  // Status carries only defined codes.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.status == ST_OK || out_result.status == ST_EMPTY
      || out_result.status == ST_FULL)
    else $error("undefined status code");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("block not idle after reset");

endmodule

bind max_frequency_stack mfs_checker u_mfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_result(out_result)
);

[verif/tb.sv]
// Testbench for the maximum frequency stack: directed and random pushes and pops checked against a model.
`timescale 1ns / 100ps

class freq_stack_scoreboard;
  mfs_pkg::mfs_rsp_t pending_rsp[$];
  int errors;

  // Model state of the stack.
  logic [29:0] key_val[256];
  int          key_cnt[256];
  bit          key_used[256];
  logic [29:0] ent_val[1024];
  int          ent_below[1024];
  int          lvl_top[1024];
  int          lvl_size[1024];
  int          free_list[1024];
  int          free_num;
  int          top_lvl;

  function new();
    errors = 0;
    for (int i = 0; i < 256; i++) begin
      key_used[i] = 0;
      key_cnt[i] = 0;
    end
    for (int i = 0; i < 1024; i++) begin
      lvl_size[i] = 0;
      lvl_top[i] = 0;
      free_list[i] = i;
    end
    free_num = 1024;
    top_lvl = 0;
  endfunction

  function int find_slot(logic [29:0] v);
    for (int s = 0; s < 256; s++)
      if (key_used[s] && key_val[s] == v) return s;
    return -1;
  endfunction

  function void note_request(mfs_pkg::mfs_req_t req);
    mfs_pkg::mfs_rsp_t r;
    int slot, lvl, idx;
    logic [29:0] v;
    r.popped_value = '0;
    r.status = mfs_pkg::ST_OK;
    if (req.req_type == mfs_pkg::REQ_PUSH) begin
      v = req.push_value & mfs_pkg::VALUE_MASK;
      slot = find_slot(v);
      if (free_num == 0) r.status = mfs_pkg::ST_FULL;
      else begin
        if (slot < 0) begin
          for (int s = 0; s < 256 && slot < 0; s++)
            if (!key_used[s]) slot = s;
          if (slot >= 0) begin
            key_used[slot] = 1;
            key_val[slot] = v;
            key_cnt[slot] = 0;
          end
        end
        if (slot < 0) r.status = mfs_pkg::ST_FULL;
        else begin
          key_cnt[slot]++;
          lvl = key_cnt[slot];
          free_num--;
          idx = free_list[free_num];
          ent_val[idx] = v;
          ent_below[idx] = lvl_top[lvl-1];
          lvl_top[lvl-1] = idx;
          lvl_size[lvl-1]++;
          if (lvl > top_lvl) top_lvl = lvl;
        end
      end
    end else if (top_lvl == 0 || lvl_size[top_lvl-1] == 0) begin
      r.status = mfs_pkg::ST_EMPTY;
    end else begin
      lvl = top_lvl;
      idx = lvl_top[lvl-1];
      v = ent_val[idx];
      lvl_top[lvl-1] = ent_below[idx];
      lvl_size[lvl-1]--;
      free_list[free_num] = idx;
      free_num++;
      slot = find_slot(v);
      if (slot >= 0) begin
        if (key_cnt[slot] > 0) key_cnt[slot]--;
        if (key_cnt[slot] == 0) key_used[slot] = 0;
      end
      if (lvl_size[lvl-1] == 0) top_lvl = lvl - 1;
      r.popped_value = v;
    end
    pending_rsp.push_back(r);
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  function void check_result(mfs_pkg::mfs_rsp_t got);
    mfs_pkg::mfs_rsp_t exp_rsp;
    if (pending_rsp.size() == 0) begin
      report($sformatf("unexpected result %h", got));
      return;
    end
    exp_rsp = pending_rsp.pop_front();
    if (got.status !== exp_rsp.status)
      report($sformatf("status %0d, wanted %0d", got.status, exp_rsp.status));
    if (got.popped_value !== exp_rsp.popped_value)
      report($sformatf("value %h, wanted %h", got.popped_value, exp_rsp.popped_value));
  endfunction
endclass

module tb;
  import mfs_pkg::*;

  logic     clk = 0;
  logic     rst_n = 0;
  logic     start = 0;
  logic     busy;
  mfs_req_t in_req = '0;
  logic     out_valid;
  mfs_rsp_t out_result;

  freq_stack_scoreboard sb = new();
  int idle_cycles = 0;
  logic [29:0] hot_vals[8];

  max_frequency_stack dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_request(in_req);
    if (rst_n && out_valid) sb.check_result(out_result);
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance, with start
  // still high so that a following transaction can go out without a gap.
  task automatic send(logic op, logic [29:0] v);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      in_req <= {1'b0, 30'($urandom)};
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_req <= '{req_type: op, push_value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    in_req <= {1'b0, 30'($urandom)};
    while (sb.pending_rsp.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [29:0] v;
    int n;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: empty pops, extremes, ties and frequency order.
    send(REQ_POP, 30'h3fffffff);
    send(REQ_PUSH, 30'h0);
    send(REQ_PUSH, 30'h3fffffff);
    send(REQ_PUSH, 30'h0);
    send(REQ_PUSH, 30'h2aaaaaaa);
    send(REQ_PUSH, 30'h15555555);
    send(REQ_PUSH, 30'h3fffffff);
    repeat (7) send(REQ_POP, 30'h0);
    // Random phase: hot values to build deep levels, plus noise.
    for (int i = 0; i < 8; i++) hot_vals[i] = 30'($urandom);
    for (int i = 0; i < 100; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = hot_vals[$urandom_range(0, 7)];
        4: v = 30'($urandom);
        default: v = 30'($urandom_range(0, 15));
      endcase
      if ($urandom_range(0, 99) < ((i / 25) % 2 ? 60 : 35)) send(REQ_POP, v);
      else send(REQ_PUSH, v);
    end
    // Pause with everything answered, then empty the stack and pop once more.
    drain();
    n = 1024 - sb.free_num;
    repeat (n + 1) send(REQ_POP, 30'h0);
    // Distinct-value capacity: 257 distinct values, last one rejected.
    for (int i = 0; i < 257; i++) send(REQ_PUSH, 30'(i * 7 + 100));
    send(REQ_PUSH, 30'd100);
    // Entry capacity: fill the remaining entries with a few known values, then one more.
    for (int i = 0; i < 768; i++) send(REQ_PUSH, 30'(100 + 7 * (i % 5)));
    // Pops from the full stack walk the deep levels.
    repeat (20) send(REQ_POP, 30'h0);
    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

[max_frequency_stack.f]
src/mfs_pkg.sv
src/max_frequency_stack.sv
src/mfs_checker.sv
verif/tb.sv
